// ===== src/bxds_pkg.sv =====
// Shared types, constants and codes for the box average downscaler.
package bxds_pkg;

   localparam int PIX_W         = 8;
   localparam int NUM_CH        = 3;
   localparam int QUOT_W        = 8;
   localparam int STEP_W        = 3;
   localparam int FACTOR_REG_W  = 5;
   localparam int WIDTH_REG_W   = 12;
   localparam int HEIGHT_W      = 16;
   localparam int CSR_INDEX_W   = 2;
   localparam int CSR_DATA_W    = 16;

   localparam int DEF_MAX_WIDTH   = 2048;
   localparam int DEF_MAX_FACTOR  = 16;
   localparam int DEF_OUT_COLUMNS = 1024;

   localparam logic [FACTOR_REG_W-1:0] RST_BLOCK_FACTOR = 5'd1;
   localparam logic [WIDTH_REG_W-1:0]  RST_FRAME_WIDTH  = 12'd640;
   localparam logic [HEIGHT_W-1:0]     RST_FRAME_HEIGHT = 16'd480;

   localparam logic [CSR_INDEX_W-1:0] CSR_BLOCK_FACTOR = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_WIDTH  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT = 2'd2;

   typedef struct packed {
      logic [PIX_W-1:0] red_in;
      logic [PIX_W-1:0] green_in;
      logic [PIX_W-1:0] blue_in;
   } req_type;

   typedef struct packed {
      logic [PIX_W-1:0] red_out;
      logic [PIX_W-1:0] green_out;
      logic [PIX_W-1:0] blue_out;
      logic             frame_end;
   } rsp_type;

   typedef enum logic [1:0] {
      DIV_IDLE,
      DIV_RUN,
      DIV_DONE
   } div_state_type;

endpackage

// ===== src/bxds_divider.sv =====
// Restoring divider that turns three block sums into rounded averages, one bit per cycle.
module bxds_divider #(
   parameter int SUM_W = 16,
   parameter int CNT_W = 9
)(
   input  logic                                           clock,
   input  logic                                           reset,
   input  logic                                           start,
   input  logic [bxds_pkg::NUM_CH-1:0][SUM_W-1:0]         sums,
   input  logic [CNT_W-1:0]                               count,
   input  logic                                           last,
   input  logic                                           take,
   output logic                                           busy,
   output logic                                           done,
   output logic [bxds_pkg::NUM_CH-1:0][bxds_pkg::QUOT_W-1:0] quot,
   output logic                                           last_out
);
   import bxds_pkg::*;

   localparam int N_W = SUM_W + 1;

   div_state_type                        state_ff, state_in;
   logic [STEP_W-1:0]                    step_ff, step_in;
   logic [N_W-1:0]                       dsh_ff, dsh_in;
   logic [NUM_CH-1:0][N_W-1:0]           rem_ff, rem_in;
   logic [NUM_CH-1:0][QUOT_W-1:0]        quot_ff, quot_in;
   logic                                 last_ff, last_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DIV_IDLE;
      end else begin
         state_ff <= state_in;
      end
      step_ff <= step_in;
      dsh_ff  <= dsh_in;
      rem_ff  <= rem_in;
      quot_ff <= quot_in;
      last_ff <= last_in;
   end

   // The average is (2*sum + count) / (2*count), which never exceeds eight bits.
   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      dsh_in   = dsh_ff;
      rem_in   = rem_ff;
      quot_in  = quot_ff;
      last_in  = last_ff;
      case (state_ff)
         DIV_IDLE: begin
            if (start) begin
               for (int ch = 0; ch < NUM_CH; ch++) begin
                  rem_in[ch]  = N_W'({sums[ch], 1'b0}) + N_W'(count);
                  quot_in[ch] = '0;
               end
               dsh_in   = N_W'({count, 1'b0}) << (QUOT_W - 1);
               step_in  = '0;
               last_in  = last;
               state_in = DIV_RUN;
            end
         end
         DIV_RUN: begin
            for (int ch = 0; ch < NUM_CH; ch++) begin
               if (rem_ff[ch] >= dsh_ff) begin
                  rem_in[ch]  = rem_ff[ch] - dsh_ff;
                  quot_in[ch] = {quot_ff[ch][QUOT_W-2:0], 1'b1};
               end else begin
                  quot_in[ch] = {quot_ff[ch][QUOT_W-2:0], 1'b0};
               end
            end
            dsh_in  = dsh_ff >> 1;
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(QUOT_W - 1)) begin
               state_in = DIV_DONE;
            end
         end
         DIV_DONE: begin
            if (take) begin
               state_in = DIV_IDLE;
            end
         end
         default: begin
            state_in = DIV_IDLE;
         end
      endcase
   end

   assign busy     = (state_ff != DIV_IDLE);
   assign done     = (state_ff == DIV_DONE);
   assign quot     = quot_ff;
   assign last_out = last_ff;

endmodule

// ===== src/box_average_downscaler_unit.sv =====
// Top level of the box average downscaler: position tracking, block sum memory and output.
// Pixels arrive in raster order and every factor-by-factor block is averaged per channel
// with round-half-up rounding; partial blocks of an image smaller than the factor use the
// pixels present, and leftover columns and rows produce nothing. With a factor of 0 or 1
// every pixel passes straight through at one item per cycle unless the output stalls.
// Otherwise each pixel is added to its block column's sums in an on-chip memory by a
// read-modify-write with a registered read, with forwarding between back-to-back pixels
// of the same block. The pixel that completes a block holds the input off through the
// memory update, the bit-per-cycle divider and the hand-off into the output register; a
// stalled output prolongs the hold. A write to any of the three configuration
// registers restarts the frame at its first pixel. The sum memory needs no clearing pass,
// since each block row starts its sums from zero.
module box_average_downscaler_unit #(
   parameter int MAX_WIDTH   = bxds_pkg::DEF_MAX_WIDTH,
   parameter int MAX_FACTOR  = bxds_pkg::DEF_MAX_FACTOR,
   parameter int OUT_COLUMNS = bxds_pkg::DEF_OUT_COLUMNS
)(
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  bxds_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output bxds_pkg::rsp_type                   rsp_data,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [bxds_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [bxds_pkg::CSR_DATA_W-1:0]     csr_data
);
   import bxds_pkg::*;

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int WEF_W  = $clog2(MAX_WIDTH + 1);
   localparam int FW     = $clog2(MAX_FACTOR + 1);
   localparam int CIB_W  = $clog2(MAX_FACTOR);
   localparam int XW     = $clog2(MAX_WIDTH + 2 * MAX_FACTOR + 1);
   localparam int YW     = $clog2((2 ** HEIGHT_W) + 2 * MAX_FACTOR);
   localparam int SUM_W  = PIX_W + $clog2(MAX_FACTOR * MAX_FACTOR);
   localparam int CNT_W  = $clog2(MAX_FACTOR * MAX_FACTOR + 1);
   localparam int ADDR_W = (OUT_COLUMNS > 1) ? $clog2(OUT_COLUMNS) : 1;

   logic [FACTOR_REG_W-1:0] factor_ff;
   logic [WIDTH_REG_W-1:0]  width_ff;
   logic [HEIGHT_W-1:0]     height_ff;

   logic [COL_W-1:0]    col_ff, col_in;
   logic [HEIGHT_W-1:0] row_ff, row_in;
   logic [CIB_W-1:0]    cib_ff, cib_in;
   logic [CIB_W-1:0]    rib_ff, rib_in;
   logic [COL_W-1:0]    bx_ff, bx_in;

   logic [FW-1:0]       f_eff;
   logic [WEF_W-1:0]    w_eff;
   logic [HEIGHT_W-1:0] h_eff;
   logic                pass;
   logic                cfg_hit;
   logic                req_acc;
   logic                rsp_free;

   logic [XW-1:0] col_x, w_x, fx, bstart_x, cend_x;
   logic [YW-1:0] row_y, h_y, fy, rstart_y, rend_y;
   logic          col_ok, row_ok, bx_ok, blk_hit;
   logic          col_last, row_last, last_col, last_row;
   logic [FW-1:0] cols_in, rows_in;
   logic          cib_inc_ok, rib_inc_ok;
   logic          emit;
   logic [CNT_W-1:0] count;

   logic                                  stb_valid_ff;
   logic [ADDR_W-1:0]                     stb_addr_ff;
   logic                                  stb_clear_ff;
   logic                                  stb_emit_ff;
   logic                                  stb_last_ff;
   logic [CNT_W-1:0]                      stb_count_ff;
   logic [NUM_CH-1:0][PIX_W-1:0]          stb_pix_ff;

   logic [NUM_CH-1:0][SUM_W-1:0] sum_mem [OUT_COLUMNS];
   logic [NUM_CH-1:0][SUM_W-1:0] rd_data_ff;
   logic [NUM_CH-1:0][SUM_W-1:0] sum_new;
   logic [ADDR_W-1:0]            rd_addr;
   logic                         mem_rd;
   logic                         fwd_valid_ff;
   logic [ADDR_W-1:0]            fwd_addr_ff;
   logic [NUM_CH-1:0][SUM_W-1:0] fwd_data_ff;
   logic                         fwd_hit;

   logic                             div_start;
   logic                             div_busy;
   logic                             div_done;
   logic                             div_take;
   logic [NUM_CH-1:0][QUOT_W-1:0]    div_quot;
   logic                             div_last;

   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff;

   // Effective register values.
   always_comb begin
      if (32'(factor_ff) > MAX_FACTOR) begin
         f_eff = FW'(MAX_FACTOR);
      end else begin
         f_eff = FW'(factor_ff);
      end
      if (width_ff == '0) begin
         w_eff = WEF_W'(1);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         w_eff = WEF_W'(MAX_WIDTH);
      end else begin
         w_eff = WEF_W'(width_ff);
      end
      h_eff = (height_ff == '0) ? HEIGHT_W'(1) : height_ff;
   end

   assign pass     = (f_eff <= FW'(1));
   assign csr_ready = 1'b1;
   assign cfg_hit  = csr_valid && ((csr_index == CSR_BLOCK_FACTOR) ||
                                   (csr_index == CSR_FRAME_WIDTH) ||
                                   (csr_index == CSR_FRAME_HEIGHT));
   assign rsp_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = pass ? rsp_free : (!div_busy && !(stb_valid_ff && stb_emit_ff));
   assign req_acc  = req_valid && req_ready;

   // Block geometry of the pixel at the current position.
   always_comb begin
      col_x    = XW'(col_ff);
      w_x      = XW'(w_eff);
      fx       = XW'(f_eff);
      bstart_x = col_x - XW'(cib_ff);
      cend_x   = bstart_x + fx;
      col_ok   = (bstart_x == '0) || (cend_x <= w_x);
      col_last = (cend_x + fx) > w_x;
      cols_in  = (cend_x > w_x) ? FW'(w_x - bstart_x) : f_eff;
      last_col = (col_x + XW'(1)) == w_x;

      row_y    = YW'(row_ff);
      h_y      = YW'(h_eff);
      fy       = YW'(f_eff);
      rstart_y = row_y - YW'(rib_ff);
      rend_y   = rstart_y + fy;
      row_ok   = (rstart_y == '0) || (rend_y <= h_y);
      row_last = (rend_y + fy) > h_y;
      rows_in  = (rend_y > h_y) ? FW'(h_y - rstart_y) : f_eff;
      last_row = (row_y + YW'(1)) == h_y;

      bx_ok      = 32'(bx_ff) < OUT_COLUMNS;
      blk_hit    = col_ok && row_ok && bx_ok;
      emit       = ((FW'(cib_ff) + FW'(1)) == cols_in) && ((FW'(rib_ff) + FW'(1)) == rows_in);
      count      = CNT_W'(cols_in) * CNT_W'(rows_in);
      cib_inc_ok = (FW'(cib_ff) + FW'(1)) < f_eff;
      rib_inc_ok = (FW'(rib_ff) + FW'(1)) < f_eff;
   end

   // Raster position update.
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      cib_in = cib_ff;
      rib_in = rib_ff;
      bx_in  = bx_ff;
      if (cfg_hit || (req_acc && last_col && last_row)) begin
         col_in = '0;
         row_in = '0;
         cib_in = '0;
         rib_in = '0;
         bx_in  = '0;
      end else if (req_acc && last_col) begin
         col_in = '0;
         cib_in = '0;
         bx_in  = '0;
         row_in = row_ff + 1'b1;
         rib_in = (!pass && rib_inc_ok) ? rib_ff + 1'b1 : '0;
      end else if (req_acc) begin
         col_in = col_ff + 1'b1;
         if (!pass && cib_inc_ok) begin
            cib_in = cib_ff + 1'b1;
         end else begin
            cib_in = '0;
            if (!pass) begin
               bx_in = bx_ff + 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         factor_ff    <= RST_BLOCK_FACTOR;
         width_ff     <= RST_FRAME_WIDTH;
         height_ff    <= RST_FRAME_HEIGHT;
         col_ff       <= '0;
         row_ff       <= '0;
         cib_ff       <= '0;
         rib_ff       <= '0;
         bx_ff        <= '0;
         stb_valid_ff <= 1'b0;
         fwd_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid && (csr_index == CSR_BLOCK_FACTOR)) begin
            factor_ff <= csr_data[FACTOR_REG_W-1:0];
         end
         if (csr_valid && (csr_index == CSR_FRAME_WIDTH)) begin
            width_ff <= csr_data[WIDTH_REG_W-1:0];
         end
         if (csr_valid && (csr_index == CSR_FRAME_HEIGHT)) begin
            height_ff <= csr_data[HEIGHT_W-1:0];
         end
         col_ff       <= col_in;
         row_ff       <= row_in;
         cib_ff       <= cib_in;
         rib_ff       <= rib_in;
         bx_ff        <= bx_in;
         stb_valid_ff <= mem_rd;
         fwd_valid_ff <= stb_valid_ff;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Read stage: fetch the running sums of this block column.
   assign mem_rd  = req_acc && !pass && blk_hit;
   assign rd_addr = ADDR_W'(bx_ff);

   always_ff @(posedge clock) begin
      if (mem_rd) begin
         stb_addr_ff  <= rd_addr;
         stb_clear_ff <= (cib_ff == '0) && (rib_ff == '0);
         stb_emit_ff  <= emit;
         stb_last_ff  <= col_last && row_last;
         stb_count_ff <= count;
         stb_pix_ff   <= {req_data.red_in, req_data.green_in, req_data.blue_in};
      end
   end

   // Update stage: add the pixel and write back; the last write is forwarded to the next read.
   assign fwd_hit = fwd_valid_ff && (fwd_addr_ff == stb_addr_ff);

   always_comb begin
      for (int ch = 0; ch < NUM_CH; ch++) begin
         if (stb_clear_ff) begin
            sum_new[ch] = SUM_W'(stb_pix_ff[ch]);
         end else if (fwd_hit) begin
            sum_new[ch] = fwd_data_ff[ch] + SUM_W'(stb_pix_ff[ch]);
         end else begin
            sum_new[ch] = rd_data_ff[ch] + SUM_W'(stb_pix_ff[ch]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stb_valid_ff) begin
         sum_mem[stb_addr_ff] <= sum_new;
      end
      if (mem_rd) begin
         rd_data_ff <= sum_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      fwd_addr_ff <= stb_addr_ff;
      fwd_data_ff <= sum_new;
   end

   assign div_start = stb_valid_ff && stb_emit_ff;
   assign div_take  = div_done && rsp_free;

   bxds_divider #(
      .SUM_W (SUM_W),
      .CNT_W (CNT_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .sums     (sum_new),
      .count    (stb_count_ff),
      .last     (stb_last_ff),
      .take     (div_take),
      .busy     (div_busy),
      .done     (div_done),
      .quot     (div_quot),
      .last_out (div_last)
   );

   // Output register.
   assign rsp_valid_in = (req_acc && pass) || div_take || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (req_acc && pass) begin
         rsp_data_ff.red_out   <= req_data.red_in;
         rsp_data_ff.green_out <= req_data.green_in;
         rsp_data_ff.blue_out  <= req_data.blue_in;
         rsp_data_ff.frame_end <= last_col && last_row;
      end else if (div_take) begin
         rsp_data_ff.red_out   <= div_quot[2];
         rsp_data_ff.green_out <= div_quot[1];
         rsp_data_ff.blue_out  <= div_quot[0];
         rsp_data_ff.frame_end <= div_last;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== src/bxds_checker.sv =====
// Port-level checks for the box average downscaler and their binding to the top level.
module bxds_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_valid,
   input logic                             rsp_ready,
   input bxds_pkg::rsp_type                rsp_data,
   input logic                             csr_ready
);
   import bxds_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("Result item dropped before it was taken.");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_data))
      else $error("Result item changed while stalled.");

   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("Result item shown right after reset.");

   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      csr_ready)
      else $error("Configuration port not ready.");

endmodule

bind box_average_downscaler_unit bxds_checker u_bxds_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data),
   .csr_ready (csr_ready)
);

// ===== test/box_average_downscaler_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the box average downscaler with its own block average predictor.
module box_average_downscaler_unit_tb;
   import bxds_pkg::*;

   localparam int SETTLE_CYCLES  = 20;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int RANDOM_ITEMS   = 300;
   localparam int MIN_FRAMES     = 4;
   localparam int MAX_REPORTS    = 100;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED = 2'd3;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_type                req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_type                rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   int send_idle_pct = 0;
   int stall_pct = 0;
   int error_count = 0;
   int pixels_in = 0;
   int averages_out = 0;
   int csr_writes = 0;
   int quiet_cycles = 0;

   logic [FACTOR_REG_W-1:0] factor_reg;
   logic [WIDTH_REG_W-1:0]  width_reg;
   logic [HEIGHT_W-1:0]     height_reg;
   int unsigned red_sum [DEF_OUT_COLUMNS];
   int unsigned green_sum [DEF_OUT_COLUMNS];
   int unsigned blue_sum [DEF_OUT_COLUMNS];
   int unsigned column_at;
   int unsigned row_at;
   int unsigned block_row;
   rsp_type expected_pixels[$];

   box_average_downscaler_unit uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   task automatic restart_position();
      column_at = 0;
      row_at = 0;
      block_row = 0;
   endtask

   task automatic reset_predictor();
      factor_reg = RST_BLOCK_FACTOR;
      width_reg = RST_FRAME_WIDTH;
      height_reg = RST_FRAME_HEIGHT;
      for (int i = 0; i < DEF_OUT_COLUMNS; i++) begin
         red_sum[i] = 0;
         green_sum[i] = 0;
         blue_sum[i] = 0;
      end
      restart_position();
   endtask

   task automatic apply_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      case (idx)
         CSR_BLOCK_FACTOR: begin
            factor_reg = value[FACTOR_REG_W-1:0];
            restart_position();
         end
         CSR_FRAME_WIDTH: begin
            width_reg = value[WIDTH_REG_W-1:0];
            restart_position();
         end
         CSR_FRAME_HEIGHT: begin
            height_reg = value[HEIGHT_W-1:0];
            restart_position();
         end
         default: begin
         end
      endcase
   endtask

   function automatic logic [PIX_W-1:0] round_average(input int unsigned sum,
                                                      input int unsigned cnt);
      return PIX_W'((2 * sum + cnt) / (2 * cnt));
   endfunction

   task automatic predict_block_average(input req_type px);
      int unsigned f, w, h, c, y, out_w, out_h, bx, by, end_c, end_r, cnt;
      bit last_px;
      rsp_type avg;
      f = (factor_reg > DEF_MAX_FACTOR) ? DEF_MAX_FACTOR : factor_reg;
      w = (width_reg == 0) ? 1 : ((width_reg > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : width_reg);
      h = (height_reg == 0) ? 1 : height_reg;
      c = column_at;
      y = row_at;
      last_px = (c + 1 == w) && (y + 1 == h);
      if (f <= 1) begin
         avg.red_out = px.red_in;
         avg.green_out = px.green_in;
         avg.blue_out = px.blue_in;
         avg.frame_end = last_px;
         expected_pixels.push_back(avg);
      end else begin
         out_w = w / f;
         out_h = h / f;
         bx = c / f;
         by = y / f;
         if (out_w == 0) out_w = 1;
         if (out_h == 0) out_h = 1;
         if (bx < out_w && by < out_h && bx < DEF_OUT_COLUMNS) begin
            end_c = bx * f + f;
            end_r = by * f + f;
            if (end_c > w) end_c = w;
            if (end_r > h) end_r = h;
            if (block_row == 0 && c % f == 0) begin
               red_sum[bx] = 0;
               green_sum[bx] = 0;
               blue_sum[bx] = 0;
            end
            red_sum[bx] += px.red_in;
            green_sum[bx] += px.green_in;
            blue_sum[bx] += px.blue_in;
            if (c + 1 == end_c && y + 1 == end_r) begin
               cnt = (end_c - bx * f) * (end_r - by * f);
               avg.red_out = round_average(red_sum[bx], cnt);
               avg.green_out = round_average(green_sum[bx], cnt);
               avg.blue_out = round_average(blue_sum[bx], cnt);
               avg.frame_end = (bx + 1 == out_w) && (by + 1 == out_h);
               expected_pixels.push_back(avg);
            end
         end
      end
      if (last_px || y >= h || c >= w) begin
         restart_position();
      end else if (c + 1 == w) begin
         column_at = 0;
         row_at = y + 1;
         block_row = (f > 1 && block_row + 1 < f) ? block_row + 1 : 0;
      end else begin
         column_at = c + 1;
      end
   endtask

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      error_count++;
      if (error_count <= MAX_REPORTS)
         $display("Mismatch in %s at %0t: got %0d, expected %0d", what, $realtime, got, want);
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         reset_predictor();
      end else begin
         if (csr_valid && csr_ready) begin
            apply_csr(csr_index, csr_data);
            csr_writes++;
         end
         if (req_valid && req_ready) begin
            predict_block_average(req_data);
            pixels_in++;
         end
         if (rsp_valid && rsp_ready) begin
            averages_out++;
            if (expected_pixels.size() == 0) begin
               report_mismatch("item with none pending", rsp_data, 0);
            end else begin
               want = expected_pixels.pop_front();
               if (rsp_data.red_out !== want.red_out)
                  report_mismatch("red_out", rsp_data.red_out, want.red_out);
               if (rsp_data.green_out !== want.green_out)
                  report_mismatch("green_out", rsp_data.green_out, want.green_out);
               if (rsp_data.blue_out !== want.blue_out)
                  report_mismatch("blue_out", rsp_data.blue_out, want.blue_out);
               if (rsp_data.frame_end !== want.frame_end)
                  report_mismatch("frame_end", rsp_data.frame_end, want.frame_end);
            end
         end
         if ((csr_valid && csr_ready) || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("Watchdog expired with %0d items pending", expected_pixels.size());
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   task automatic set_idle_mode(input idle_mode_type mode);
      case (mode)
         IDLE_NONE: begin
            send_idle_pct = 0;
            stall_pct = 0;
         end
         IDLE_SENDER: begin
            send_idle_pct = 55;
            stall_pct = 0;
         end
         IDLE_RECEIVER: begin
            send_idle_pct = 0;
            stall_pct = 55;
         end
         default: begin
            send_idle_pct = 21;
            stall_pct = 21;
         end
      endcase
   endtask

   task automatic send_pixel(input logic [PIX_W-1:0] r, input logic [PIX_W-1:0] g,
                             input logic [PIX_W-1:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{red_in: r, green_in: g, blue_in: b};
      do begin
         @(posedge clock);
      end while (!req_ready);
   endtask

   // The first edge lets the checker record the item taken at the edge just passed.
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_pixels.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do begin
         @(posedge clock);
      end while (!csr_ready);
   endtask

   // Unused upper data bits carry noise, since the block keeps only the register width.
   task automatic set_frame(input logic [FACTOR_REG_W-1:0] f, input logic [WIDTH_REG_W-1:0] w,
                            input logic [HEIGHT_W-1:0] h);
      logic [CSR_DATA_W-1:0] noise;
      noise = CSR_DATA_W'($urandom());
      drain();
      write_csr(CSR_BLOCK_FACTOR, {noise[CSR_DATA_W-1:FACTOR_REG_W], f});
      write_csr(CSR_FRAME_WIDTH, {noise[CSR_DATA_W-1:WIDTH_REG_W], w});
      write_csr(CSR_FRAME_HEIGHT, h);
      csr_valid <= 1'b0;
   endtask

   task automatic send_random_pixel();
      send_pixel(PIX_W'($urandom_range(255)), PIX_W'($urandom_range(255)),
                 PIX_W'($urandom_range(255)));
   endtask

   task automatic test_reset_defaults();
      set_idle_mode(IDLE_NONE);
      send_pixel(8'h00, 8'h00, 8'h00);
      send_pixel(8'hFF, 8'hFF, 8'hFF);
      send_pixel(8'h55, 8'hAA, 8'h0F);
   endtask

   // A 3x3 frame at factor 2 leaves one column and one row over; blue sits exactly on a half.
   task automatic test_block_rounding();
      set_frame(5'd2, 12'd3, 16'd3);
      send_pixel(8'hFF, 8'h01, 8'h01);
      send_pixel(8'hFF, 8'h00, 8'h00);
      send_pixel(8'h07, 8'h07, 8'h07);
      send_pixel(8'hFE, 8'h00, 8'h01);
      send_pixel(8'hFF, 8'h00, 8'h00);
      send_pixel(8'h09, 8'h09, 8'h09);
      send_pixel(8'hFF, 8'hFF, 8'hFF);
      send_pixel(8'h00, 8'h00, 8'h00);
      send_pixel(8'h80, 8'h80, 8'h80);
   endtask

   // A factor above the maximum on a frame smaller than one block.
   task automatic test_small_image();
      set_frame(5'd20, 12'd3, 16'd2);
      send_pixel(8'hFF, 8'h00, 8'h10);
      send_pixel(8'hFF, 8'h00, 8'h20);
      send_pixel(8'hFF, 8'h00, 8'h30);
      send_pixel(8'h00, 8'hFF, 8'h40);
      send_pixel(8'h00, 8'hFF, 8'h50);
      send_pixel(8'h01, 8'hFF, 8'h61);
   endtask

   task automatic test_degenerate_sizes();
      set_frame(5'd0, 12'd0, 16'd0);
      send_pixel(8'h12, 8'h34, 8'h56);
      send_pixel(8'hFF, 8'h00, 8'hFF);
      send_pixel(8'h00, 8'hFF, 8'h00);
   endtask

   // Width beyond the line store and zero height: a single clamped row of 2048 pixels.
   task automatic test_wide_row();
      set_idle_mode(IDLE_BOTH);
      set_frame(5'd2, 12'hFFF, 16'd0);
      for (int i = 0; i < DEF_MAX_WIDTH + 4; i++)
         send_random_pixel();
   endtask

   task automatic test_random_frames();
      int unsigned f, w, h, wv, hv, frame_px, count, split;
      int sent;
      int phase;
      sent = 0;
      phase = 0;
      while (sent < RANDOM_ITEMS || phase < MIN_FRAMES) begin
         set_idle_mode(idle_mode_type'(phase % 4));
         case ($urandom_range(9))
            0: f = $urandom_range(1);
            1: f = $urandom_range(31, 17);
            2: f = DEF_MAX_FACTOR;
            default: f = $urandom_range(6, 2);
         endcase
         w = ($urandom_range(15) == 0) ? 0 : $urandom_range(16, 1);
         h = ($urandom_range(15) == 0) ? 0 : $urandom_range(18, 1);
         wv = (w == 0) ? 1 : w;
         hv = (h == 0) ? 1 : h;
         frame_px = wv * hv;
         if ($urandom_range(4) == 0)
            count = $urandom_range(2 * frame_px, 1);
         else
            count = frame_px * $urandom_range(3, 1);
         split = ($urandom_range(3) == 0) ? $urandom_range(count - 1) : count;
         set_frame(FACTOR_REG_W'(f), WIDTH_REG_W'(w), HEIGHT_W'(h));
         for (int i = 0; i < count; i++) begin
            if (i == split && i != 0) begin
               drain();
               write_csr(CSR_UNMAPPED, CSR_DATA_W'($urandom()));
               csr_valid <= 1'b0;
            end
            send_random_pixel();
         end
         sent += count;
         phase++;
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_reset_defaults();
      test_block_rounding();
      test_small_image();
      test_degenerate_sizes();
      test_wide_row();
      test_random_frames();
      drain();
      $display("Sent %0d pixels and %0d register writes, checked %0d output pixels.",
               pixels_in, csr_writes, averages_out);
      $display("Factors from pass-through to clamped, frames from one pixel to a 2048-wide row.");
      if (error_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
src/bxds_pkg.sv
src/bxds_divider.sv
src/box_average_downscaler_unit.sv
src/bxds_checker.sv
test/box_average_downscaler_unit_tb.sv
